// ===== src/rutm_pkg.sv =====
// Shared types, codes and constants of the resource usage threshold monitor.
`timescale 1ns / 1ps
package rutm_pkg;

    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int RES_W       = 4;
    localparam int SLOT_W      = 3;
    localparam int EVENT_W     = 2;
    localparam int ALARM_W     = 4;
    localparam int PCT_W       = 7;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;

    // Percentage divider: numerator is used*100, denominator used+available.
    localparam int DIV_NUM_W   = 40;
    localparam int DIV_DEN_W   = DATA_W + 1;
    localparam int DIV_STEPS   = PCT_W;
    localparam int DIV_CNT_W   = 3;
    localparam int PCT_SCALE   = 100;

    localparam int DEF_RESOURCE_KINDS     = 16;
    localparam int DEF_SLOTS_PER_RESOURCE = 8;
    localparam int DEF_ALARM_LIMIT        = 10;

    localparam logic [DATA_W-1:0] LOW_THRESHOLD_RST  = 32'd70;
    localparam logic [DATA_W-1:0] HIGH_THRESHOLD_RST = 32'd85;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [EVENT_W-1:0] t_event;

    localparam t_func FUNC_INC   = 2'd0;
    localparam t_func FUNC_DEC   = 2'd1;
    localparam t_func FUNC_LOAD  = 2'd2;
    localparam t_func FUNC_CHECK = 2'd3;

    localparam t_mode MODE_PCT  = 2'd0;
    localparam t_mode MODE_USED = 2'd1;
    localparam t_mode MODE_FREE = 2'd2;
    localparam t_mode MODE_OFF  = 2'd3;

    localparam t_event EV_NONE     = 2'd0;
    localparam t_event EV_EXCEEDED = 2'd1;
    localparam t_event EV_CLEARED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd2;

    typedef struct packed {
        t_mode             mode;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] high;
    } t_cfg;

endpackage

// ===== src/rutm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rutm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rutm_div.sv =====
// Restoring divider for the used percentage, one quotient bit per cycle.
`timescale 1ns / 1ps
module rutm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rutm_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [rutm_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [rutm_pkg::PCT_W-1:0]      o_quot
);
    import rutm_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0]  r_rem, n_rem;
    logic [DIV_NUM_W-1:0]  r_dsh, n_dsh;
    logic [PCT_W-1:0]      r_quot, n_quot;
    logic                  w_fit;

    // Quotient never exceeds 100, so the divisor starts shifted by PCT_W-1.
    assign w_fit = (r_rem >= r_dsh);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_dsh  = DIV_NUM_W'(i_den) << (DIV_STEPS - 1);
            n_quot = '0;
        end else if (r_busy) begin
            if (w_fit) begin
                n_rem = r_rem - r_dsh;
            end
            n_quot = {r_quot[PCT_W-2:0], w_fit};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== src/rutm_cfg.sv =====
// Configuration registers: threshold mode and the shared low and high thresholds.
`timescale 1ns / 1ps
module rutm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [rutm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rutm_pkg::DATA_W-1:0]      i_cfg_data,
    output logic                             o_cfg_ready,
    output rutm_pkg::t_cfg                   o_cfg
);
    import rutm_pkg::*;

    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: n_cfg.mode = i_cfg_data[MODE_W-1:0];
                CFG_LOW:  n_cfg.low  = i_cfg_data;
                CFG_HIGH: n_cfg.high = i_cfg_data;
                default:  n_cfg = r_cfg;  // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_PCT;
            r_cfg.low  <= LOW_THRESHOLD_RST;
            r_cfg.high <= HIGH_THRESHOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ===== src/resource_usage_threshold_monitor.sv =====
// Top level: sequencer over the count RAMs, alarm RAM and shared percentage divider.
`timescale 1ns / 1ps
// Flow: an out-of-range address goes from accept to FINISH; any other passes READ, UPD,
// PCT, DIV (7-step restoring divider, skipped for a zero used count), CHECK, FINISH.
// Throughput: one request at a time; the next is taken once the result is in the
// output register, even while that result is still stalled.
// Reset: a clearing pass over all RESOURCE_KINDS*SLOTS_PER_RESOURCE addresses (128 at the
// defaults) zeroes all counts and alarms; no request is taken meanwhile.
module resource_usage_threshold_monitor #(
    parameter int RESOURCE_KINDS     = rutm_pkg::DEF_RESOURCE_KINDS,
    parameter int SLOTS_PER_RESOURCE = rutm_pkg::DEF_SLOTS_PER_RESOURCE,
    parameter int ALARM_LIMIT        = rutm_pkg::DEF_ALARM_LIMIT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rutm_pkg::t_func                  i_func,
    input  logic [rutm_pkg::RES_W-1:0]       i_resource_index,
    input  logic [rutm_pkg::SLOT_W-1:0]      i_slot_index,
    input  logic [rutm_pkg::DATA_W-1:0]      i_load_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rutm_pkg::t_event                 o_event_res,
    output logic [rutm_pkg::DATA_W-1:0]      o_measure,
    output logic [rutm_pkg::PCT_W-1:0]       o_percent_used,
    output logic [rutm_pkg::DATA_W-1:0]      o_used_now,
    output logic [rutm_pkg::DATA_W-1:0]      o_available_now,
    output logic [rutm_pkg::ALARM_W-1:0]     o_alarm_level,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rutm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rutm_pkg::DATA_W-1:0]      i_cfg_data
);
    import rutm_pkg::*;

    localparam int DEPTH  = RESOURCE_KINDS * SLOTS_PER_RESOURCE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AL_W   = (RESOURCE_KINDS > 1) ? $clog2(RESOURCE_KINDS) : 1;
    localparam logic [DIV_NUM_W-1:0] SCALE = DIV_NUM_W'(PCT_SCALE);
    localparam logic [ALARM_W-1:0]   ALARM_MAX = ALARM_W'(ALARM_LIMIT);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_UPD, S_PCT, S_DIV, S_CHECK, S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    t_func               r_func, n_func;
    logic [RES_W-1:0]    r_res, n_res;
    logic [DATA_W-1:0]   r_load, n_load;
    logic [DATA_W-1:0]   r_used, n_used;
    logic [DATA_W-1:0]   r_avail, n_avail;
    logic [ALARM_W-1:0]  r_alarm, n_alarm;
    logic [PCT_W-1:0]    r_pct, n_pct;
    logic [DATA_W-1:0]   r_meas, n_meas;
    t_event              r_ev, n_ev;

    logic                r_out_valid, n_out_valid;
    t_event              r_o_ev, n_o_ev;
    logic [DATA_W-1:0]   r_o_meas, n_o_meas;
    logic [PCT_W-1:0]    r_o_pct, n_o_pct;
    logic [DATA_W-1:0]   r_o_used, n_o_used;
    logic [DATA_W-1:0]   r_o_avail, n_o_avail;
    logic [ALARM_W-1:0]  r_o_alarm, n_o_alarm;

    t_cfg                w_cfg;
    logic                w_in_acc;
    logic                w_oor;
    logic                w_slot_free;

    logic                w_cnt_we;
    logic [ADDR_W-1:0]   w_cnt_waddr;
    logic [DATA_W-1:0]   w_used_wdata;
    logic [DATA_W-1:0]   w_avail_wdata;
    logic [DATA_W-1:0]   w_used_rd;
    logic [DATA_W-1:0]   w_avail_rd;
    logic                w_al_we;
    logic [AL_W-1:0]     w_al_addr;
    logic [ALARM_W-1:0]  w_al_wdata;
    logic [ALARM_W-1:0]  w_al_rd;

    logic                w_div_start;
    logic                w_div_done;
    logic [PCT_W-1:0]    w_quot;
    logic [DIV_NUM_W-1:0] w_num;
    logic [DIV_DEN_W-1:0] w_den;

    rutm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    rutm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_used_rd)
    );

    rutm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_avail_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_avail_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_avail_rd)
    );

    rutm_ram #(.WIDTH(ALARM_W), .DEPTH(RESOURCE_KINDS)) u_alarm_ram (
        .i_clk   (i_clk),
        .i_we    (w_al_we),
        .i_waddr (w_al_addr),
        .i_wdata (w_al_wdata),
        .i_raddr (AL_W'(r_res)),
        .o_rdata (w_al_rd)
    );

    assign w_num       = DIV_NUM_W'(r_used) * SCALE;
    assign w_den       = DIV_DEN_W'(r_used) + DIV_DEN_W'(r_avail);
    assign w_div_start = (r_state == S_PCT) && (r_used != '0);

    rutm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_oor       = (int'(i_resource_index) >= RESOURCE_KINDS) ||
                         (int'(i_slot_index) >= SLOTS_PER_RESOURCE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // RAM write side: zeros during the clearing pass, updated counts afterwards.
    assign w_cnt_we      = (r_state == S_CLEAR) || (r_state == S_UPD);
    assign w_cnt_waddr   = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign w_used_wdata  = (r_state == S_CLEAR) ? '0 : n_used;
    assign w_avail_wdata = (r_state == S_CLEAR) ? '0 : n_avail;
    assign w_al_we       = ((r_state == S_CLEAR) && (int'(r_clr) < RESOURCE_KINDS)) ||
                           ((r_state == S_CHECK) && (n_ev != EV_NONE));
    assign w_al_addr     = (r_state == S_CLEAR) ? AL_W'(r_clr) : AL_W'(r_res);
    assign w_al_wdata    = (r_state == S_CLEAR) ? '0 : n_alarm;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_func      = r_func;
        n_res       = r_res;
        n_load      = r_load;
        n_used      = r_used;
        n_avail     = r_avail;
        n_alarm     = r_alarm;
        n_pct       = r_pct;
        n_meas      = r_meas;
        n_ev        = r_ev;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_ev      = r_o_ev;
        n_o_meas    = r_o_meas;
        n_o_pct     = r_o_pct;
        n_o_used    = r_o_used;
        n_o_avail   = r_o_avail;
        n_o_alarm   = r_o_alarm;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func  = i_func;
                    n_res   = i_resource_index;
                    n_load  = i_load_value;
                    n_addr  = ADDR_W'(int'(i_resource_index) * SLOTS_PER_RESOURCE +
                                      int'(i_slot_index));
                    n_used  = '0;
                    n_avail = '0;
                    n_alarm = '0;
                    n_pct   = '0;
                    n_meas  = '0;
                    n_ev    = EV_NONE;
                    // Out-of-range requests change nothing and report all zeros.
                    n_state = w_oor ? S_FINISH : S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_used  = w_used_rd;
                n_avail = w_avail_rd;
                n_alarm = w_al_rd;
                unique case (r_func)
                    FUNC_INC: if (w_used_rd != '1) n_used = w_used_rd + 1'b1;
                    FUNC_DEC: if (w_used_rd != '0) n_used = w_used_rd - 1'b1;
                    FUNC_LOAD: n_avail = r_load;
                    FUNC_CHECK: n_used = w_used_rd;
                    default: n_used = w_used_rd;
                endcase
                n_state = S_PCT;
            end
            S_PCT: begin
                if (r_used == '0) begin
                    n_pct   = '0;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pct   = w_quot;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                unique case (w_cfg.mode)
                    MODE_PCT:  n_meas = DATA_W'(r_pct);
                    MODE_USED: n_meas = r_used;
                    MODE_FREE: n_meas = r_avail;
                    MODE_OFF:  n_meas = '0;
                    default:   n_meas = '0;
                endcase
                n_ev = EV_NONE;
                if ((r_func == FUNC_CHECK) && (w_cfg.mode != MODE_OFF)) begin
                    priority if ((n_meas >= w_cfg.high) && (r_alarm < ALARM_MAX)) begin
                        n_ev    = EV_EXCEEDED;
                        n_alarm = r_alarm + 1'b1;
                    end else if ((n_meas <= w_cfg.low) && (r_alarm != '0)) begin
                        n_ev    = EV_CLEARED;
                        n_alarm = '0;
                    end else begin
                        n_alarm = r_alarm;
                    end
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the output register is free or being taken.
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_ev      = r_ev;
                    n_o_meas    = r_meas;
                    n_o_pct     = r_pct;
                    n_o_used    = r_used;
                    n_o_avail   = r_avail;
                    n_o_alarm   = r_alarm;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_addr    <= n_addr;
        r_func    <= n_func;
        r_res     <= n_res;
        r_load    <= n_load;
        r_used    <= n_used;
        r_avail   <= n_avail;
        r_alarm   <= n_alarm;
        r_pct     <= n_pct;
        r_meas    <= n_meas;
        r_ev      <= n_ev;
        r_o_ev    <= n_o_ev;
        r_o_meas  <= n_o_meas;
        r_o_pct   <= n_o_pct;
        r_o_used  <= n_o_used;
        r_o_avail <= n_o_avail;
        r_o_alarm <= n_o_alarm;
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_o_ev;
    assign o_measure       = r_o_meas;
    assign o_percent_used  = r_o_pct;
    assign o_used_now      = r_o_used;
    assign o_available_now = r_o_avail;
    assign o_alarm_level   = r_o_alarm;

    a_exceed_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_EXCEEDED)) |-> (o_alarm_level != '0))
        else $error("exceeded event reported with zero alarm level");

    a_clear_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_CLEARED)) |-> (o_alarm_level == '0))
        else $error("cleared event reported with nonzero alarm level");

    a_pct_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_used_now == '0)) |-> (o_percent_used == '0))
        else $error("nonzero percentage reported for zero used count");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
